@@ design/esd_pkg.sv @@
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and constants for the epoch seconds to date converter.
// ----------------------------------------------------------------------------
package esd_pkg;

   localparam int unsigned SecWidth  = 32;
   localparam int unsigned DayWidth  = 16;   // days since epoch fit below 49711
   localparam int unsigned RemWidth  = 17;   // remainder below 86400

   localparam logic [RemWidth-1:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [RemWidth-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [RemWidth-1:0] SECS_PER_MIN  = 17'd60;

   // x / (2^s * d) = ((x >> s) * m) >> k with m = ceil(2^k / d), exact over the
   // operand range used here
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;   // d = 675, s = 7, k = 35
   localparam logic [13:0] HOUR_RECIP = 14'd9321;       // d = 225, s = 4, k = 21
   localparam logic [10:0] MIN_RECIP  = 11'd1093;       // d = 15,  s = 2, k = 14

   localparam logic [7:0] BASE_YEAR_OFS   = 8'd70;    // 1970 - 1900
   localparam logic [7:0] NON_LEAP_CENTRY = 8'd200;   // 2100 - 1900

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_DAY,
      ST_END_DAY,
      ST_DIV_HOUR,
      ST_END_HOUR,
      ST_DIV_MIN,
      ST_END_MIN,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV,
      OP_END_DAY,
      OP_END_HOUR,
      OP_END_MIN,
      OP_YEAR,
      OP_MONTH
   } op_type;

   typedef enum logic [1:0] {
      DV_DAY,
      DV_HOUR,
      DV_MIN
   } divsel_type;

   typedef struct packed {
      op_type     op;
      divsel_type divsel;
   } cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } status_type;

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon) inside
         4'd1:                      len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

@@ design/epoch_seconds_to_date.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_date
// Converts unsigned 32-bit seconds since 1970-01-01 into Gregorian date/time.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; the
//   seconds count is sampled there. busy stays high until the result has
//   been shown. The result appears on the rsp_ ports for exactly one cycle
//   with rsp_valid high; the receiver cannot hold it off, so it must take
//   it then. One request is in flight at a time.
//   The time from the accepting edge to the rsp_valid cycle grows with the
//   number of whole years since 1970 and with the month index. It is set by
//   constant division (a quotient and a remainder step each for days, hours
//   and minutes), by the year and month counters, one year or month per
//   cycle plus a last step each that stops it, and by the done state that
//   shows the result. A new request may follow in the cycle after rsp_valid.
//   Reset is synchronous and returns the sequencer to idle; any request in
//   flight is dropped and no result is shown for it.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   output logic [7:0]  rsp_year_since_1900,
   output logic [3:0]  rsp_month_index,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour_of_day,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [5:0]  rsp_second_of_minute
);
   import esd_pkg::*;

   cmd_type    cmd;
   status_type status;

   esd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   esd_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .epoch_seconds    (req_epoch_seconds),
      .status           (status),
      .year_since_1900  (rsp_year_since_1900),
      .month_index      (rsp_month_index),
      .day_of_month     (rsp_day_of_month),
      .hour_of_day      (rsp_hour_of_day),
      .minute_of_hour   (rsp_minute_of_hour),
      .second_of_minute (rsp_second_of_minute)
   );

endmodule

@@ design/esd_ctrl.sv @@
// ----------------------------------------------------------------------------
// esd_ctrl
// Sequencer: quotient and remainder steps for days, hours and minutes, then
// the year and month walks.
// ----------------------------------------------------------------------------
module esd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  esd_pkg::status_type status,
   output esd_pkg::cmd_type    cmd,
   output logic               busy,
   output logic               done
);
   import esd_pkg::*;

   state_type  state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DIV_DAY;
         end
         ST_DIV_DAY:  state_in = ST_END_DAY;
         ST_END_DAY:  state_in = ST_DIV_HOUR;
         ST_DIV_HOUR: state_in = ST_END_HOUR;
         ST_END_HOUR: state_in = ST_DIV_MIN;
         ST_DIV_MIN:  state_in = ST_END_MIN;
         ST_END_MIN:  state_in = ST_YEAR;
         ST_YEAR:     if (status.year_done) state_in = ST_MONTH;
         ST_MONTH:    if (status.month_done) state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd.op     = OP_NONE;
      cmd.divsel = DV_DAY;
      busy       = 1'b1;
      done       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) cmd.op = OP_LOAD;
         end
         ST_DIV_DAY:  cmd.op = OP_DIV;
         ST_END_DAY:  cmd.op = OP_END_DAY;
         ST_DIV_HOUR: begin
            cmd.op     = OP_DIV;
            cmd.divsel = DV_HOUR;
         end
         ST_END_HOUR: cmd.op = OP_END_HOUR;
         ST_DIV_MIN: begin
            cmd.op     = OP_DIV;
            cmd.divsel = DV_MIN;
         end
         ST_END_MIN:  cmd.op = OP_END_MIN;
         ST_YEAR:     cmd.op = OP_YEAR;
         ST_MONTH:    cmd.op = OP_MONTH;
         ST_DONE:     done = 1'b1;
         default:     busy = 1'b1;
      endcase
   end

endmodule

@@ design/esd_datapath.sv @@
// ----------------------------------------------------------------------------
// esd_datapath
// Reciprocal-multiply division by 86400 / 3600 / 60, plus year and month
// counters.
// ----------------------------------------------------------------------------
module esd_datapath (
   input  logic                clock,
   input  esd_pkg::cmd_type    cmd,
   input  logic [31:0]         epoch_seconds,
   output esd_pkg::status_type status,
   output logic [7:0]          year_since_1900,
   output logic [3:0]          month_index,
   output logic [4:0]          day_of_month,
   output logic [4:0]          hour_of_day,
   output logic [5:0]          minute_of_hour,
   output logic [5:0]          second_of_minute
);
   import esd_pkg::*;

   logic [SecWidth-1:0] num_ff, num_in;
   logic [RemWidth-1:0] rem_ff, rem_in;
   logic [DayWidth-1:0] days_ff, days_in;
   logic [7:0]          year_ff, year_in;
   logic [3:0]          mon_ff, mon_in;
   logic [4:0]          hour_ff, hour_in;
   logic [5:0]          min_ff, min_in;
   logic [5:0]          sec_ff, sec_in;

   logic [50:0]         day_prod;
   logic [26:0]         hour_prod;
   logic [20:0]         min_prod;
   logic [31:0]         day_back;
   logic [31:0]         day_left;
   logic [RemWidth-1:0] hour_back;
   logic [11:0]         min_back;
   logic [11:0]         min_left;
   logic                leap;
   logic [8:0]          year_len;
   logic [4:0]          mon_len;

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      days_ff <= days_in;
      year_ff <= year_in;
      mon_ff  <= mon_in;
      hour_ff <= hour_in;
      min_ff  <= min_in;
      sec_ff  <= sec_in;
   end

   // quotients: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
   assign day_prod  = 51'(num_ff[SecWidth-1:7]) * 51'(DAY_RECIP);
   assign hour_prod = 27'(rem_ff[RemWidth-1:4]) * 27'(HOUR_RECIP);
   assign min_prod  = 21'(rem_ff[11:2]) * 21'(MIN_RECIP);      // remainder below 3600

   // remainders from the registered quotients
   assign day_back  = 32'(days_ff) * 32'(SECS_PER_DAY);
   assign day_left  = num_ff - day_back;
   assign hour_back = 17'(hour_ff) * SECS_PER_HOUR;
   assign min_back  = 12'(min_ff) * 12'(SECS_PER_MIN);
   assign min_left  = rem_ff[11:0] - min_back;

   // years counted from 1900; 2100 is the only century in range that is not leap
   assign leap     = (year_ff[1:0] == 2'b00) && (year_ff != NON_LEAP_CENTRY);
   assign year_len = leap ? 9'd366 : 9'd365;
   assign mon_len  = month_len(mon_ff, leap);

   assign status.year_done  = days_ff < {{(DayWidth-9){1'b0}}, year_len};
   assign status.month_done = days_ff < {{(DayWidth-5){1'b0}}, mon_len};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      days_in = days_ff;
      year_in = year_ff;
      mon_in  = mon_ff;
      hour_in = hour_ff;
      min_in  = min_ff;
      sec_in  = sec_ff;
      case (cmd.op)
         OP_LOAD: begin
            num_in = epoch_seconds;
         end
         OP_DIV: begin
            case (cmd.divsel)
               DV_HOUR: hour_in = hour_prod[25:21];
               DV_MIN:  min_in  = min_prod[19:14];
               default: days_in = day_prod[50:35];
            endcase
         end
         OP_END_DAY: begin
            rem_in = day_left[RemWidth-1:0];
         end
         OP_END_HOUR: begin
            rem_in = rem_ff - hour_back;
         end
         OP_END_MIN: begin
            sec_in  = min_left[5:0];
            year_in = BASE_YEAR_OFS;
            mon_in  = '0;
         end
         OP_YEAR: begin
            if (!status.year_done) begin
               days_in = days_ff - {{(DayWidth-9){1'b0}}, year_len};
               year_in = year_ff + 8'd1;
            end
         end
         OP_MONTH: begin
            if (!status.month_done) begin
               days_in = days_ff - {{(DayWidth-5){1'b0}}, mon_len};
               mon_in  = mon_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign year_since_1900  = year_ff;
   assign month_index      = mon_ff;
   assign day_of_month     = days_ff[4:0] + 5'd1;
   assign hour_of_day      = hour_ff;
   assign minute_of_hour   = min_ff;
   assign second_of_minute = sec_ff;

endmodule

@@ design/esd_checker.sv @@
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks on the converter's request/result sequencing.
// ----------------------------------------------------------------------------
module esd_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [3:0] rsp_month_index,
   input logic [4:0] rsp_day_of_month,
   input logic [4:0] rsp_hour_of_day
);

   // result strobe lasts a single cycle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held for more than one cycle");

   // an accepted request keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // no result without a request in flight
   a_strobe_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   a_fields_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_index <= 4'd11) && (rsp_day_of_month != 5'd0)
                    && (rsp_hour_of_day <= 5'd23))
      else $error("result field out of range");

endmodule

bind epoch_seconds_to_date esd_checker u_esd_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_month_index  (rsp_month_index),
   .rsp_day_of_month (rsp_day_of_month),
   .rsp_hour_of_day  (rsp_hour_of_day)
);
